>>> hdl/plw_pkg.sv
package plw_pkg;

  // Sizes of the neighbour store.
  localparam int MAX_NBR = 64;
  localparam int NBR_AW  = $clog2(MAX_NBR);
  localparam int CNT_W   = NBR_AW + 1;

  // Field widths.
  localparam int IDX_W   = 26;
  localparam int COORD_W = 32;
  localparam int WGT_W   = 32;
  localparam int FRAC_W  = 28;

  // Internal fixed-point widths.
  localparam int OFS_W   = COORD_W + 1;      // offset, Q2.30
  localparam int PROD_W  = 2 * OFS_W;        // offset product
  localparam int MOM_SH  = 8;                // moment scale shift
  localparam int MOM_W   = 64;
  localparam int OSUM_W  = 40;
  localparam int SC_W    = 29;               // scaled solve operands
  localparam int ADJ_W   = 58;
  localparam int VEC_W   = 88;
  localparam int BIG_W   = 96;
  localparam int ACC_W   = 128;
  localparam int CHUNK_W = 32;
  localparam int PP_W    = CHUNK_W + SC_W;
  localparam int H_W     = 6;
  localparam int H_INIT  = 4;
  localparam int OP_W    = 5;

  localparam int DIV_STEPS = ACC_W + FRAC_W;

  // Command codes.
  localparam logic CMD_TARGET    = 1'b0;
  localparam logic CMD_NEIGHBOUR = 1'b1;

  // Sequencer program indexes.
  localparam logic [OP_W-1:0] OP_SOLVE_LAST = 5'd23;
  localparam logic [OP_W-1:0] OP_NUM_FIRST  = 5'd24;

  typedef enum logic [1:0] {BIG_IP, BIG_ADJ, BIG_VEC} big_src_t;
  typedef enum logic [1:0] {SML_IP, SML_RP, SML_DA} sml_src_t;
  typedef enum logic [1:0] {DST_ADJ, DST_DELTA, DST_VEC, DST_NUM} dst_t;

  typedef struct packed {
    big_src_t   big;
    logic [2:0] big_k;
    sml_src_t   sml;
    logic [2:0] sml_k;
    logic       sub;
    logic       first;
    logic       last;
    dst_t       dst;
    logic [2:0] dst_k;
  } op_t;

  typedef struct packed {
    logic [OFS_W-1:0] dz;
    logic [OFS_W-1:0] dy;
    logic [OFS_W-1:0] dx;
    logic [IDX_W-1:0] col;
  } nbr_row_t;

  function automatic op_t mk_op(big_src_t b, logic [2:0] bk, sml_src_t s, logic [2:0] sk,
                                logic sub, logic first, logic last, dst_t d,
                                logic [2:0] dk);
    op_t o;
    o.big   = b;
    o.big_k = bk;
    o.sml   = s;
    o.sml_k = sk;
    o.sub   = sub;
    o.first = first;
    o.last  = last;
    o.dst   = d;
    o.dst_k = dk;
    return o;
  endfunction

  // Multiply-accumulate program: adjugate, determinant, adj*R, then the
  // per-neighbour numerator delta - d'.(adj*R).
  function automatic op_t op_decode(logic [OP_W-1:0] idx);
    op_t o;
    unique case (idx)
      5'd0:  o = mk_op(BIG_IP,  3'd3, SML_IP, 3'd5, 1'b0, 1'b1, 1'b0, DST_ADJ,   3'd0);
      5'd1:  o = mk_op(BIG_IP,  3'd4, SML_IP, 3'd4, 1'b1, 1'b0, 1'b1, DST_ADJ,   3'd0);
      5'd2:  o = mk_op(BIG_IP,  3'd2, SML_IP, 3'd4, 1'b0, 1'b1, 1'b0, DST_ADJ,   3'd1);
      5'd3:  o = mk_op(BIG_IP,  3'd1, SML_IP, 3'd5, 1'b1, 1'b0, 1'b1, DST_ADJ,   3'd1);
      5'd4:  o = mk_op(BIG_IP,  3'd1, SML_IP, 3'd4, 1'b0, 1'b1, 1'b0, DST_ADJ,   3'd2);
      5'd5:  o = mk_op(BIG_IP,  3'd2, SML_IP, 3'd3, 1'b1, 1'b0, 1'b1, DST_ADJ,   3'd2);
      5'd6:  o = mk_op(BIG_IP,  3'd0, SML_IP, 3'd5, 1'b0, 1'b1, 1'b0, DST_ADJ,   3'd3);
      5'd7:  o = mk_op(BIG_IP,  3'd2, SML_IP, 3'd2, 1'b1, 1'b0, 1'b1, DST_ADJ,   3'd3);
      5'd8:  o = mk_op(BIG_IP,  3'd1, SML_IP, 3'd2, 1'b0, 1'b1, 1'b0, DST_ADJ,   3'd4);
      5'd9:  o = mk_op(BIG_IP,  3'd0, SML_IP, 3'd4, 1'b1, 1'b0, 1'b1, DST_ADJ,   3'd4);
      5'd10: o = mk_op(BIG_IP,  3'd0, SML_IP, 3'd3, 1'b0, 1'b1, 1'b0, DST_ADJ,   3'd5);
      5'd11: o = mk_op(BIG_IP,  3'd1, SML_IP, 3'd1, 1'b1, 1'b0, 1'b1, DST_ADJ,   3'd5);
      5'd12: o = mk_op(BIG_ADJ, 3'd0, SML_IP, 3'd0, 1'b0, 1'b1, 1'b0, DST_DELTA, 3'd0);
      5'd13: o = mk_op(BIG_ADJ, 3'd1, SML_IP, 3'd1, 1'b0, 1'b0, 1'b0, DST_DELTA, 3'd0);
      5'd14: o = mk_op(BIG_ADJ, 3'd2, SML_IP, 3'd2, 1'b0, 1'b0, 1'b1, DST_DELTA, 3'd0);
      5'd15: o = mk_op(BIG_ADJ, 3'd0, SML_RP, 3'd0, 1'b0, 1'b1, 1'b0, DST_VEC,   3'd0);
      5'd16: o = mk_op(BIG_ADJ, 3'd1, SML_RP, 3'd1, 1'b0, 1'b0, 1'b0, DST_VEC,   3'd0);
      5'd17: o = mk_op(BIG_ADJ, 3'd2, SML_RP, 3'd2, 1'b0, 1'b0, 1'b1, DST_VEC,   3'd0);
      5'd18: o = mk_op(BIG_ADJ, 3'd1, SML_RP, 3'd0, 1'b0, 1'b1, 1'b0, DST_VEC,   3'd1);
      5'd19: o = mk_op(BIG_ADJ, 3'd3, SML_RP, 3'd1, 1'b0, 1'b0, 1'b0, DST_VEC,   3'd1);
      5'd20: o = mk_op(BIG_ADJ, 3'd4, SML_RP, 3'd2, 1'b0, 1'b0, 1'b1, DST_VEC,   3'd1);
      5'd21: o = mk_op(BIG_ADJ, 3'd2, SML_RP, 3'd0, 1'b0, 1'b1, 1'b0, DST_VEC,   3'd2);
      5'd22: o = mk_op(BIG_ADJ, 3'd4, SML_RP, 3'd1, 1'b0, 1'b0, 1'b0, DST_VEC,   3'd2);
      5'd23: o = mk_op(BIG_ADJ, 3'd5, SML_RP, 3'd2, 1'b0, 1'b0, 1'b1, DST_VEC,   3'd2);
      5'd24: o = mk_op(BIG_VEC, 3'd0, SML_DA, 3'd0, 1'b1, 1'b1, 1'b0, DST_NUM,   3'd0);
      5'd25: o = mk_op(BIG_VEC, 3'd1, SML_DA, 3'd1, 1'b1, 1'b0, 1'b0, DST_NUM,   3'd0);
      5'd26: o = mk_op(BIG_VEC, 3'd2, SML_DA, 3'd2, 1'b1, 1'b0, 1'b1, DST_NUM,   3'd0);
      default: o = mk_op(BIG_IP, 3'd0, SML_IP, 3'd0, 1'b0, 1'b1, 1'b1, DST_DELTA, 3'd0);
    endcase
    return o;
  endfunction

endpackage

>>> hdl/plw_div.sv
module plw_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [plw_pkg::ACC_W-1:0] num,
  input  logic signed [plw_pkg::ACC_W-1:0] den,
  output logic                             done,
  output logic signed [plw_pkg::WGT_W-1:0] quo
);
  import plw_pkg::*;

  // Quotient bits kept before the result is known to saturate.
  localparam int Q_W   = WGT_W + 3;
  localparam int STP_W = $clog2(DIV_STEPS);
  localparam logic [STP_W-1:0] STEP_LAST = STP_W'(DIV_STEPS - 1);
  localparam logic [Q_W-1:0]   POS_MAX   = Q_W'((64'd1 << (WGT_W - 1)) - 64'd1);

  logic             run_r, fin_r, done_r;
  logic             neg_r, sat_r;
  logic [ACC_W-1:0] n_r, d_r, r_r;
  logic [Q_W-1:0]   q_r;
  logic [STP_W-1:0] cnt_r;
  logic signed [WGT_W-1:0] quo_r;

  logic [ACC_W:0]   rs, diff;
  logic             ge, rnd;
  logic [Q_W-1:0]   qf;

  // One restoring step per cycle; numerator bits enter most significant first.
  assign rs   = {r_r, n_r[ACC_W-1]};
  assign diff = rs - {1'b0, d_r};
  assign ge   = (rs >= {1'b0, d_r});
  assign rnd  = ({r_r, 1'b0} >= {1'b0, d_r}) && !sat_r;
  assign qf   = q_r + Q_W'(rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r <= num[ACC_W-1] ^ den[ACC_W-1];
        n_r   <= num[ACC_W-1] ? -num : num;
        d_r   <= den[ACC_W-1] ? -den : den;
        r_r   <= '0;
        q_r   <= '0;
        sat_r <= 1'b0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        r_r <= ge ? diff[ACC_W-1:0] : rs[ACC_W-1:0];
        n_r <= n_r << 1;
        if (!sat_r) begin
          q_r   <= {q_r[Q_W-2:0], ge};
          sat_r <= q_r[Q_W-2];
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        if (neg_r) begin
          if (sat_r || qf > POS_MAX) quo_r <= {1'b1, {(WGT_W-1){1'b0}}};
          else                       quo_r <= -$signed(qf[WGT_W-1:0]);
        end else begin
          if (sat_r || qf > POS_MAX) quo_r <= {1'b0, {(WGT_W-1){1'b1}}};
          else                       quo_r <= $signed(qf[WGT_W-1:0]);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r && !fin_r) else $error("divider restarted while busy");
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && fin_r)) else $error("divider run and finish overlap");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(fin_r)) else $error("divider done without finish step");
`endif

endmodule

>>> hdl/pseudo_laplace_weights.sv
// Pseudo-Laplacian interpolation weights for one target point.
// Input channel: a transfer happens at a rising edge with start high and
// busy low. Command 0 loads the target point and its row index and clears
// the sums; command 1 adds one neighbour, and a neighbour that carries
// in_last_neighbour starts the solve. A neighbour keeps busy high while
// the six products of the second moments are summed. After the last
// neighbour the block scales the sums (one shift step per cycle, until
// every sum fits in SC_W signed bits), runs 24 multiply-accumulate steps
// on one shared 32 x 29 bit multiplier, then the multiply-accumulate steps
// of each neighbour's numerator, and finally one division per result on
// the one-bit-per-cycle divider. busy stays high through all of that.
// Result channel: out_valid marks each result for exactly one cycle, in
// arrival order of the neighbours; the receiver cannot stall it, so every
// strobe is one transfer. out_last_weight marks the final one.
// Reset (rst_n low at a clock edge) clears the target, the sums and the
// neighbour count. The neighbour memories are not cleared: only entries
// written since the last clear are ever read.
module pseudo_laplace_weights (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic signed [plw_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [plw_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [plw_pkg::COORD_W-1:0] in_coord_z,
  input  logic        [plw_pkg::IDX_W-1:0]   in_point_index,
  input  logic                               in_last_neighbour,
  output logic                               out_valid,
  output logic        [plw_pkg::IDX_W-1:0]   out_row_index,
  output logic        [plw_pkg::IDX_W-1:0]   out_column_index,
  output logic signed [plw_pkg::WGT_W-1:0]   out_weight,
  output logic                               out_last_weight,
  output logic                               out_degenerate
);
  import plw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NBR, S_PREP, S_SCALE, S_ISSUE, S_MUL, S_STORE,
    S_RDROW, S_DA, S_CHK, S_RD2, S_DIVGO, S_DIVW
  } state_t;

  localparam logic [2:0] MOM_LAST = 3'd6;
  localparam logic [1:0] MC_LAST  = 2'd3;

  state_t state_r;

  // Target and sums.
  logic signed [COORD_W-1:0] tgt_r [3];
  logic [IDX_W-1:0]          row_r;
  logic signed [MOM_W-1:0]   mom_r [6];
  logic signed [OSUM_W-1:0]  osum_r [3];
  logic [CNT_W-1:0]          cnt_r;

  // Neighbour intake.
  logic signed [OFS_W-1:0]   d_r [3];
  logic [IDX_W-1:0]          col_in_r;
  logic                      last_r;
  logic [2:0]                k_r;
  logic signed [PROD_W-1:0]  mp_r;
  logic signed [OFS_W-1:0]   mop_a, mop_b;

  // Scaling and solve operands.
  logic signed [MOM_W-1:0]   sh_m_r [6];
  logic signed [OSUM_W-1:0]  sh_o_r [3];
  logic [H_W-1:0]            h_r;
  logic signed [SC_W-1:0]    ip_r [6];
  logic signed [SC_W-1:0]    rp_r [3];
  logic signed [SC_W-1:0]    da_r [3];
  logic signed [ADJ_W-1:0]   adj_r [6];
  logic signed [VEC_W-1:0]   vec_r [3];
  logic signed [ACC_W-1:0]   delta_r, acc_r, sum_r;
  logic                      scale_ok;

  // Shared multiplier.
  logic [OP_W-1:0]           op_r;
  op_t                       cur_op;
  logic [BIG_W-1:0]          mag_a_r;
  logic [SC_W-1:0]           mag_b_r;
  logic                      eff_r;
  logic [1:0]                mc_r;
  logic [PP_W-1:0]           pp_r;
  logic signed [BIG_W-1:0]   big_val;
  logic signed [SC_W-1:0]    sml_val;
  logic [ACC_W-1:0]          pp_ext;

  // Memories and emission.
  nbr_row_t                  nbr_mem [MAX_NBR];
  logic [ACC_W-1:0]          num_mem [MAX_NBR];
  nbr_row_t                  nbr_rd_r;
  logic [ACC_W-1:0]          num_rd_r;
  logic                      nbr_we, num_we;
  logic [CNT_W-1:0]          j_r;
  logic [CNT_W-1:0]          j_inc;
  logic                      degen_r;
  logic [IDX_W-1:0]          col_r;

  logic                      div_start, div_done;
  logic signed [ACC_W-1:0]   div_num, div_den;
  logic signed [WGT_W-1:0]   div_quo;

  logic                      out_valid_r, out_last_r, out_degen_r;
  logic [IDX_W-1:0]          out_row_r, out_col_r;
  logic signed [WGT_W-1:0]   out_weight_r;

  logic signed [COORD_W-1:0] in_coord [3];

  assign in_coord[0] = in_coord_x;
  assign in_coord[1] = in_coord_y;
  assign in_coord[2] = in_coord_z;

  assign busy   = (state_r != S_IDLE);
  assign cur_op = op_decode(op_r);
  assign j_inc  = j_r + 1'b1;

  // Operand pair for the second-moment products: xx, xy, xz, yy, yz, zz.
  always_comb begin
    case (k_r)
      3'd0:    begin mop_a = d_r[0]; mop_b = d_r[0]; end
      3'd1:    begin mop_a = d_r[0]; mop_b = d_r[1]; end
      3'd2:    begin mop_a = d_r[0]; mop_b = d_r[2]; end
      3'd3:    begin mop_a = d_r[1]; mop_b = d_r[1]; end
      3'd4:    begin mop_a = d_r[1]; mop_b = d_r[2]; end
      default: begin mop_a = d_r[2]; mop_b = d_r[2]; end
    endcase
  end

  // A scale is good once every shifted sum fits in SC_W signed bits.
  always_comb begin
    scale_ok = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (!(&sh_m_r[i][MOM_W-1:SC_W-1]) && (|sh_m_r[i][MOM_W-1:SC_W-1])) scale_ok = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (!(&sh_o_r[i][OSUM_W-1:SC_W-1]) && (|sh_o_r[i][OSUM_W-1:SC_W-1])) scale_ok = 1'b0;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cur_op.big)
      BIG_IP:  big_val = BIG_W'(ip_r[cur_op.big_k]);
      BIG_ADJ: big_val = BIG_W'(adj_r[cur_op.big_k]);
      default: big_val = BIG_W'(vec_r[cur_op.big_k[1:0]]);
    endcase
    case (cur_op.sml)
      SML_IP:  sml_val = ip_r[cur_op.sml_k];
      SML_RP:  sml_val = rp_r[cur_op.sml_k[1:0]];
      default: sml_val = da_r[cur_op.sml_k[1:0]];
    endcase
  end

  // The partial product of chunk n is added in the next cycle, at bit 32*n.
  always_comb begin
    case (mc_r)
      2'd2:    pp_ext = ACC_W'(pp_r) << CHUNK_W;
      2'd3:    pp_ext = ACC_W'(pp_r) << (2 * CHUNK_W);
      default: pp_ext = ACC_W'(pp_r);
    endcase
  end

  assign nbr_we = (state_r == S_NBR) && (k_r == 3'd0);
  assign num_we = (state_r == S_STORE) && (cur_op.dst == DST_NUM);

  // Neighbour offsets and columns, one row per neighbour.
  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[cnt_r[NBR_AW-1:0]] <= '{dz: d_r[2], dy: d_r[1], dx: d_r[0], col: col_in_r};
    end
    nbr_rd_r <= nbr_mem[j_r[NBR_AW-1:0]];
  end

  // Numerators of the current target.
  always_ff @(posedge clk) begin
    if (num_we) begin
      num_mem[j_r[NBR_AW-1:0]] <= acc_r;
    end
    num_rd_r <= num_mem[j_r[NBR_AW-1:0]];
  end

  assign div_start = (state_r == S_DIVGO);
  assign div_num   = degen_r ? ACC_W'(1) : $signed(num_rd_r);
  assign div_den   = degen_r ? $signed(ACC_W'(cnt_r)) : sum_r;

  plw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      row_r       <= '0;
      for (int i = 0; i < 3; i++) begin
        tgt_r[i]  <= '0;
        osum_r[i] <= '0;
      end
      for (int i = 0; i < 6; i++) mom_r[i] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_command == CMD_TARGET) begin
              for (int i = 0; i < 3; i++) begin
                tgt_r[i]  <= in_coord[i];
                osum_r[i] <= '0;
              end
              for (int i = 0; i < 6; i++) mom_r[i] <= '0;
              row_r <= in_point_index;
              cnt_r <= '0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                d_r[i] <= OFS_W'(in_coord[i]) - OFS_W'(tgt_r[i]);
              end
              col_in_r <= in_point_index;
              last_r   <= in_last_neighbour;
              k_r      <= '0;
              if (cnt_r < CNT_W'(MAX_NBR)) state_r <= S_NBR;
              else if (in_last_neighbour)  state_r <= S_PREP;
            end
          end
        end

        S_NBR: begin
          if (k_r == 3'd0) begin
            for (int i = 0; i < 3; i++) osum_r[i] <= osum_r[i] + OSUM_W'(d_r[i]);
            cnt_r <= cnt_r + 1'b1;
          end
          if (k_r != MOM_LAST) mp_r <= mop_a * mop_b;
          if (k_r != 3'd0) begin
            mom_r[k_r - 3'd1] <= mom_r[k_r - 3'd1] + MOM_W'(mp_r >>> MOM_SH);
          end
          if (k_r == MOM_LAST) state_r <= last_r ? S_PREP : S_IDLE;
          else                 k_r     <= k_r + 3'd1;
        end

        S_PREP: begin
          for (int i = 0; i < 6; i++) sh_m_r[i] <= mom_r[i];
          for (int i = 0; i < 3; i++) sh_o_r[i] <= osum_r[i] >>> H_INIT;
          h_r     <= H_W'(H_INIT);
          state_r <= S_SCALE;
        end

        S_SCALE: begin
          // Moments carry the square of the offsets' scale, so they shift twice as far.
          if (scale_ok) begin
            for (int i = 0; i < 6; i++) ip_r[i] <= sh_m_r[i][SC_W-1:0];
            for (int i = 0; i < 3; i++) rp_r[i] <= sh_o_r[i][SC_W-1:0];
            op_r    <= '0;
            state_r <= S_ISSUE;
          end else begin
            for (int i = 0; i < 6; i++) sh_m_r[i] <= sh_m_r[i] >>> 2;
            for (int i = 0; i < 3; i++) sh_o_r[i] <= sh_o_r[i] >>> 1;
            h_r <= h_r + 1'b1;
          end
        end

        S_ISSUE: begin
          mag_a_r <= big_val[BIG_W-1] ? BIG_W'(-big_val) : BIG_W'(big_val);
          mag_b_r <= sml_val[SC_W-1] ? SC_W'(-sml_val) : SC_W'(sml_val);
          eff_r   <= big_val[BIG_W-1] ^ sml_val[SC_W-1] ^ cur_op.sub;
          mc_r    <= '0;
          if (cur_op.first) acc_r <= (cur_op.dst == DST_NUM) ? delta_r : '0;
          state_r <= S_MUL;
        end

        S_MUL: begin
          if (mc_r != MC_LAST) begin
            pp_r    <= mag_a_r[CHUNK_W-1:0] * mag_b_r;
            mag_a_r <= mag_a_r >> CHUNK_W;
          end
          if (mc_r != 2'd0) begin
            acc_r <= acc_r + (eff_r ? ~pp_ext : pp_ext) + ACC_W'(eff_r);
          end
          if (mc_r == MC_LAST) begin
            if (cur_op.last) begin
              state_r <= S_STORE;
            end else begin
              op_r    <= op_r + 1'b1;
              state_r <= S_ISSUE;
            end
          end else begin
            mc_r <= mc_r + 2'd1;
          end
        end

        S_STORE: begin
          case (cur_op.dst)
            DST_ADJ:   adj_r[cur_op.dst_k] <= acc_r[ADJ_W-1:0];
            DST_DELTA: delta_r <= acc_r;
            DST_VEC:   vec_r[cur_op.dst_k[1:0]] <= acc_r[VEC_W-1:0];
            default:   sum_r <= sum_r + acc_r;
          endcase
          if (cur_op.dst == DST_NUM) begin
            j_r     <= j_inc;
            state_r <= (j_inc == cnt_r) ? S_CHK : S_RDROW;
          end else if (op_r == OP_SOLVE_LAST) begin
            j_r     <= '0;
            sum_r   <= '0;
            state_r <= S_RDROW;
          end else begin
            op_r    <= op_r + 1'b1;
            state_r <= S_ISSUE;
          end
        end

        S_RDROW: state_r <= S_DA;

        S_DA: begin
          da_r[0] <= SC_W'($signed(nbr_rd_r.dx) >>> h_r);
          da_r[1] <= SC_W'($signed(nbr_rd_r.dy) >>> h_r);
          da_r[2] <= SC_W'($signed(nbr_rd_r.dz) >>> h_r);
          op_r    <= OP_NUM_FIRST;
          state_r <= S_ISSUE;
        end

        S_CHK: begin
          degen_r <= (delta_r == '0) || (sum_r == '0);
          j_r     <= '0;
          state_r <= S_RD2;
        end

        S_RD2: state_r <= S_DIVGO;

        S_DIVGO: begin
          col_r   <= nbr_rd_r.col;
          state_r <= S_DIVW;
        end

        S_DIVW: begin
          if (div_done) begin
            out_valid_r  <= 1'b1;
            out_row_r    <= row_r;
            out_col_r    <= col_r;
            out_weight_r <= div_quo;
            out_last_r   <= (j_inc == cnt_r);
            out_degen_r  <= degen_r;
            j_r          <= j_inc;
            if (j_inc == cnt_r) begin
              // Sums and count clear after emission; the target stays.
              for (int i = 0; i < 3; i++) osum_r[i] <= '0;
              for (int i = 0; i < 6; i++) mom_r[i] <= '0;
              cnt_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_RD2;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_r;
  assign out_column_index = out_col_r;
  assign out_weight       = out_weight_r;
  assign out_last_weight  = out_last_r;
  assign out_degenerate   = out_degen_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NBR)) else $error("neighbour count beyond store depth");
  a_results_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results in adjacent cycles");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_weight |-> cnt_r == '0 && state_r == S_IDLE)
    else $error("sums not cleared after final result");
  a_emit_has_rows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVGO |-> j_r < cnt_r) else $error("emission past stored neighbours");
`endif

endmodule
